// File: sv/lsrb_pkg.sv
`default_nettype none
package lsrb_pkg;

    localparam int RING_DEPTH = 512;
    localparam int MAX_DRAIN  = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(MAX_DRAIN + 1);

    localparam logic [7:0]  QUALITY_MASK    = 8'h3F;
    localparam logic [15:0] THRESHOLD_RESET = 16'd3000;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_ENABLE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_THRESHOLD = 1'd1;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [7:0]  raw_quality;
        logic [15:0] sample_angle;
        logic [15:0] sample_distance;
        logic        first_in_packet;
        logic [6:0]  max_points;
    } in_item_t;

    typedef struct packed {
        logic        point_valid;
        logic [5:0]  point_quality;
        logic [15:0] point_angle;
        logic [15:0] point_distance;
        logic        turn_start;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic        turn;
        logic [15:0] distance;
        logic [15:0] angle;
        logic [5:0]  quality;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Ring position status handed to the drain sequencer
    typedef struct packed {
        logic empty;
        logic next_empty;
    } ring_status_t;

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        ring_next = (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

endpackage
`default_nettype wire

// File: sv/lsrb_ram.sv
`default_nettype none
module lsrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/lsrb_drain.sv
`default_nettype none
module lsrb_drain (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [lsrb_pkg::CNT_W-1:0] limit,
    input  wire logic                       scan_enable,
    input  wire lsrb_pkg::ring_status_t     status,
    input  wire lsrb_pkg::entry_t           rd_entry,
    input  wire logic                       out_ready,
    output logic                            busy,
    output logic                            pop,
    output logic                            out_valid,
    output lsrb_pkg::out_item_t             out_item
);
    import lsrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_NULL,
        S_READ,
        S_WAIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] count_reg;
    logic             last_pending_reg;
    logic             out_valid_reg;
    out_item_t        out_item_reg;
    logic             out_free;
    logic             load_out;

    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == S_READ) && out_free;
    assign load_out  = ((state_reg == S_NULL) && out_free) || (state_reg == S_WAIT);
    assign busy      = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            count_reg        <= '0;
            last_pending_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_item_reg     <= '0;
        end
        else
        begin
            // load a new item, else drop the held one once taken
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        count_reg <= limit;
                        if (!scan_enable || limit == '0 || status.empty)
                        begin
                            state_reg <= S_NULL;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_NULL:
                begin
                    if (out_free)
                    begin
                        out_item_reg <= '{point_valid: 1'b0, point_quality: '0,
                                          point_angle: '0, point_distance: '0,
                                          turn_start: 1'b0, last: 1'b1};
                        state_reg    <= S_IDLE;
                    end
                end
                S_READ:
                begin
                    if (pop)
                    begin
                        last_pending_reg <= (count_reg == CNT_W'(1)) || status.next_empty;
                        count_reg        <= count_reg - CNT_W'(1);
                        state_reg        <= S_WAIT;
                    end
                end
                S_WAIT:
                begin
                    out_item_reg.point_valid     <= 1'b1;
                    out_item_reg.point_quality   <= rd_entry.quality;
                    out_item_reg.point_angle     <= rd_entry.angle;
                    out_item_reg.point_distance  <= rd_entry.distance;
                    out_item_reg.turn_start      <= rd_entry.turn;
                    out_item_reg.last            <= last_pending_reg;
                    state_reg <= last_pending_reg ? S_IDLE : S_READ;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_pop_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == S_WAIT)
        else $error("read issue not followed by data capture");

    a_wait_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |=> out_valid_reg && out_item_reg.point_valid)
        else $error("read data not loaded into output register");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("pop issued on empty ring");

    a_wait_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WAIT |-> !out_valid_reg)
        else $error("output register occupied when read data returns");

endmodule
`default_nettype wire

// File: sv/lidar_sample_ring_buffer_unit.sv
`default_nettype none
// Ring buffer for rotating range sensor samples.
// Input channel (in_valid/in_ready/in_item): an item is either a push of one
// sample or a drain request. A push with scan_enable set is stored when
// quality and distance are nonzero; the previous angle is tracked
// for start-of-turn detection on every enabled push. Pushes produce no result.
// When the ring is full the oldest point is overwritten (RING_DEPTH-1 points).
// A drain returns up to max_points (saturated to MAX_DRAIN) points, oldest
// first, on out_valid/out_ready/out_item, the last one marked with last. A
// drain with nothing to return, or with scan_enable clear, gives a single item
// with point_valid low. Throughput: pushes are taken one per cycle while no
// drain runs. A drain holds the input until its last point is loaded: each
// point is one read of the point store (registered read) followed by one load
// of the output register.
// The output register decouples the receiver: the next item is taken while
// the final result of a drain still waits. A stalled receiver holds the drain
// sequence at the next read; no point is lost.
// Reset: indices and previous angle clear, scan_enable clears and
// wrap_threshold returns to 3000. The point store is not cleared; entries are
// read only after they are written.
module lidar_sample_ring_buffer_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [lsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsrb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire lsrb_pkg::in_item_t              in_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output lsrb_pkg::out_item_t                  out_item
);
    import lsrb_pkg::*;

    logic             scan_enable_reg;
    logic [15:0]      wrap_threshold_reg;
    logic [IDX_W-1:0] write_index_reg;
    logic [IDX_W-1:0] read_index_reg;
    logic [15:0]      previous_angle_reg;

    logic             accept;
    logic             push_en;
    logic             store_en;
    logic             turn;
    logic [5:0]       quality;
    logic [IDX_W-1:0] write_index_next;
    logic [IDX_W-1:0] read_index_next;
    logic             drain_start;
    logic [CNT_W-1:0] drain_limit;
    logic             drain_busy;
    logic             pop;
    entry_t           wr_entry;
    entry_t           rd_entry;
    ring_status_t     status;

    // hold off new items while a drain sequence runs
    assign in_ready = !drain_busy;
    assign accept   = in_valid && in_ready;

    assign quality  = 6'(in_item.raw_quality & QUALITY_MASK);
    assign push_en  = accept && (in_item.operation == OP_PUSH) && scan_enable_reg;
    assign store_en = push_en && (quality != '0) && (in_item.sample_distance != '0);

    // new turn: first sample of a packet whose angle fell by more than the threshold
    assign turn = in_item.first_in_packet
               && (previous_angle_reg > in_item.sample_angle)
               && ((previous_angle_reg - in_item.sample_angle) > wrap_threshold_reg);

    assign wr_entry = '{turn: turn, distance: in_item.sample_distance,
                        angle: in_item.sample_angle, quality: quality};

    assign drain_start = accept && (in_item.operation == OP_DRAIN);
    assign drain_limit = (in_item.max_points > 7'(MAX_DRAIN))
                       ? CNT_W'(MAX_DRAIN) : CNT_W'(in_item.max_points);

    assign status.empty      = (read_index_reg == write_index_reg);
    assign status.next_empty = (ring_next(read_index_reg) == write_index_reg);

    // advance write index on store; push read index along when the ring overflows
    always_comb
    begin
        write_index_next = write_index_reg;
        read_index_next  = read_index_reg;
        if (store_en)
        begin
            write_index_next = ring_next(write_index_reg);
            if (write_index_next == read_index_reg)
            begin
                read_index_next = ring_next(read_index_reg);
            end
        end
        else if (pop)
        begin
            read_index_next = ring_next(read_index_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg    <= 1'b0;
            wrap_threshold_reg <= THRESHOLD_RESET;
            write_index_reg    <= '0;
            read_index_reg     <= '0;
            previous_angle_reg <= '0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    REG_SCAN_ENABLE:    scan_enable_reg    <= cfg_data[0];
                    REG_WRAP_THRESHOLD: wrap_threshold_reg <= cfg_data[15:0];
                    default:            ;
                endcase
            end
            if (push_en)
            begin
                previous_angle_reg <= in_item.sample_angle;
            end
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
        end
    end

    lsrb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_point_store (
        .clk     (clk),
        .wr_en   (store_en),
        .wr_addr (write_index_reg),
        .wr_data (wr_entry),
        .rd_en   (pop),
        .rd_addr (read_index_reg),
        .rd_data (rd_entry)
    );

    lsrb_drain u_drain (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (drain_start),
        .limit       (drain_limit),
        .scan_enable (scan_enable_reg),
        .status      (status),
        .rd_entry    (rd_entry),
        .out_ready   (out_ready),
        .busy        (drain_busy),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_item    (out_item)
    );

    a_no_store_during_drain: assert property (@(posedge clk) disable iff (!rst_n)
        !(store_en && pop))
        else $error("store and pop in the same cycle");

    a_ring_never_full_after_store: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |=> !status.empty)
        else $error("ring empty right after a store");

    a_pop_moves_read: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> read_index_reg == ring_next($past(read_index_reg)))
        else $error("read index did not advance on pop");

endmodule
`default_nettype wire

// File: dv/lsrb_drain_checker.sv
`timescale 1ns / 1ps
// Watch both channels and the register port, keep a shadow of the ring and
// compare every drained item against the predicted point.
module lsrb_drain_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write_en,
    input  wire logic [lsrb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsrb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    input  wire logic                            in_ready,
    input  wire lsrb_pkg::in_item_t              in_item,
    input  wire logic                            out_valid,
    input  wire logic                            out_ready,
    input  wire lsrb_pkg::out_item_t             out_item,
    output int                                   fail_count,
    output int                                   pending_points
);
    import lsrb_pkg::*;

    entry_t      ring_mem [RING_DEPTH];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    logic [15:0] prev_angle;
    logic        scan_on;
    logic [15:0] turn_threshold;
    out_item_t   expected_points [$];
    out_item_t   head_point;

    initial
    begin
        fail_count     = 0;
        pending_points = 0;
    end

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, msg);
    endfunction

    // Apply one accepted item to the shadow ring; a drain queues its points.
    function automatic void advance_ring(input in_item_t it);
        logic [5:0]  quality;
        logic        turn;
        int unsigned limit;
        int unsigned stored;
        int unsigned n;
        entry_t      e;
        out_item_t   pt;
        if (it.operation == OP_PUSH)
        begin
            if (!scan_on)
                return;
            quality = 6'(it.raw_quality & QUALITY_MASK);
            turn = it.first_in_packet && (prev_angle > it.sample_angle)
                   && ((prev_angle - it.sample_angle) > turn_threshold);
            prev_angle = it.sample_angle;
            if (quality != 0 && it.sample_distance != 0)
            begin
                e.turn     = turn;
                e.distance = it.sample_distance;
                e.angle    = it.sample_angle;
                e.quality  = quality;
                ring_mem[wr_ptr] = e;
                wr_ptr = (wr_ptr + 1) % RING_DEPTH;
                // full ring: drop the oldest point
                if (wr_ptr == rd_ptr)
                    rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            end
            return;
        end
        limit  = (it.max_points > MAX_DRAIN) ? MAX_DRAIN : it.max_points;
        stored = (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
        n      = (limit < stored) ? limit : stored;
        if (!scan_on || n == 0)
        begin
            pt      = '0;
            pt.last = 1'b1;
            expected_points.push_back(pt);
            return;
        end
        for (int k = 0; k < n; k++)
        begin
            e = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % RING_DEPTH;
            pt.point_valid    = 1'b1;
            pt.point_quality  = e.quality;
            pt.point_angle    = e.angle;
            pt.point_distance = e.distance;
            pt.turn_start     = e.turn;
            pt.last           = (k == n - 1);
            expected_points.push_back(pt);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr         = 0;
            rd_ptr         = 0;
            prev_angle     = '0;
            scan_on        = 1'b0;
            turn_threshold = THRESHOLD_RESET;
            fail_count     = 0;
            expected_points.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                    note_failure("drained item with no point expected");
                else
                begin
                    head_point = expected_points.pop_front();
                    if (out_item.point_valid !== head_point.point_valid
                        || out_item.point_quality !== head_point.point_quality
                        || out_item.point_angle !== head_point.point_angle
                        || out_item.point_distance !== head_point.point_distance
                        || out_item.turn_start !== head_point.turn_start
                        || out_item.last !== head_point.last)
                        note_failure($sformatf(
                            {"point mismatch: expected v=%0b q=%0d a=%0d d=%0d t=%0b l=%0b,",
                             " got v=%0b q=%0d a=%0d d=%0d t=%0b l=%0b"},
                            head_point.point_valid, head_point.point_quality,
                            head_point.point_angle, head_point.point_distance,
                            head_point.turn_start, head_point.last,
                            out_item.point_valid, out_item.point_quality,
                            out_item.point_angle, out_item.point_distance,
                            out_item.turn_start, out_item.last));
                end
            end
            if (cfg_write_en)
            begin
                if (cfg_index == REG_SCAN_ENABLE)
                    scan_on = cfg_data[0];
                else if (cfg_index == REG_WRAP_THRESHOLD)
                    turn_threshold = cfg_data;
            end
            if (in_valid && in_ready)
                advance_ring(in_item);
        end
        pending_points = expected_points.size();
    end

endmodule

// File: dv/tb_lidar_sample_ring_buffer_unit.sv
`timescale 1ns / 1ps
module tb_lidar_sample_ring_buffer_unit;
    import lsrb_pkg::*;

    // Cycles without any accepted item before the run is declared hung.
    // A drain moves each point by a read and an output load; stall runs at the
    // heaviest idling mix are short, so this is many times the worst gap.
    localparam int STUCK_LIMIT = 1000;
    // Idle time after the expected points drain, so that trailing pushes
    // settle before a register write.
    localparam int SETTLE_CYCLES = 8;
    localparam int SWEEP_FULL    = 360 * 64;
    localparam int FILL_COUNT    = 100;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_ready;
    out_item_t             out_item;

    int fail_count;
    int pending_points;
    int send_idle_pct;
    int recv_stall_pct;
    int sweep_angle;
    int stuck_cycles;

    lidar_sample_ring_buffer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_item      (in_item),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_item     (out_item)
    );

    lsrb_drain_checker checker_inst (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_item        (in_item),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item),
        .fail_count     (fail_count),
        .pending_points (pending_points)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: decide readiness at each falling edge so that stalls land on
    // every phase of a drain, including the cycle of the last point.
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which neither channel accepts an item.
    always @(posedge clk)
    begin
        if (!rst_n)
            stuck_cycles <= 0;
        else if ((in_valid && in_ready) || (out_valid && out_ready))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("FAIL lidar_sample_ring_buffer_unit");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 52; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default:       begin send_idle_pct = 22; recv_stall_pct = 22; end
        endcase
    endtask

    // Offer one item; called and returning at a falling edge. Valid stays
    // high across back-to-back items and drops only during a gap.
    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, let every expected point drain, then let trailing pushes
    // settle so a register write cannot land on a sample in flight.
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_points != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic in_item_t sample_item(input logic [7:0] raw, input logic [15:0] ang,
                                             input logic [15:0] range_q2, input logic first);
        in_item_t it;
        it                 = '0;
        it.operation       = OP_PUSH;
        it.raw_quality     = raw;
        it.sample_angle    = ang;
        it.sample_distance = range_q2;
        it.first_in_packet = first;
        return it;
    endfunction

    function automatic in_item_t drain_item(input logic [6:0] n);
        in_item_t it;
        it            = '0;
        it.operation  = OP_DRAIN;
        it.max_points = n;
        return it;
    endfunction

    // Mostly a sweeping angle like a real rotating head, with a new packet
    // flag at the wrap; now and then a jump anywhere, or a dud sample.
    function automatic in_item_t random_sample();
        in_item_t it;
        it = $bits(in_item_t)'({$urandom, $urandom});
        it.operation = OP_PUSH;
        if ($urandom_range(9) != 0)
        begin
            sweep_angle += $urandom_range(1, 600);
            if (sweep_angle >= SWEEP_FULL)
            begin
                sweep_angle -= SWEEP_FULL;
                it.first_in_packet = 1'b1;
            end
            else
                it.first_in_packet = ($urandom_range(3) == 0);
            it.sample_angle = 16'(sweep_angle);
        end
        if ($urandom_range(9) == 0)
            it.raw_quality[5:0] = '0;
        if ($urandom_range(9) == 0)
            it.sample_distance = '0;
        return it;
    endfunction

    // One phase: settle, program both registers, then a random mix of
    // samples and drain requests of all sizes.
    task automatic run_phase(input idle_mode_t mode, input logic [15:0] threshold,
                             input logic enable, input int count);
        in_item_t it;
        int       pick;
        wait_quiet();
        write_reg(REG_WRAP_THRESHOLD, threshold);
        write_reg(REG_SCAN_ENABLE, 16'(enable));
        set_idling(mode);
        repeat (count)
        begin
            if ($urandom_range(99) < 18)
            begin
                it = $bits(in_item_t)'({$urandom, $urandom});
                it.operation = OP_DRAIN;
                pick = $urandom_range(19);
                if (pick < 12)
                    it.max_points = 7'($urandom_range(1, 16));
                else if (pick < 14)
                    it.max_points = '0;
                else if (pick < 16)
                    it.max_points = 7'(MAX_DRAIN);
                else if (pick < 18)
                    it.max_points = 7'($urandom_range(MAX_DRAIN + 1, 127));
                else
                    it.max_points = 7'($urandom_range(17, MAX_DRAIN - 1));
            end
            else
                it = random_sample();
            send_item(it);
        end
    endtask

    initial
    begin
        in_item_t it;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_write_en   = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        out_ready      = 1'b0;
        rst_n          = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        sweep_angle    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Out of reset the scanner is off: the sample is dropped and the
        // drain answers with a single empty item.
        send_item(sample_item(8'hFF, 16'd100, 16'd5, 1'b0));
        send_item(drain_item(7'd4));
        wait_quiet();
        write_reg(REG_SCAN_ENABLE, 16'd1);

        // Enabled, reset threshold. Empty ring first.
        send_item(drain_item(7'd4));
        // zero quality bits and zero distance are tracked but not stored
        send_item(sample_item(8'h40, 16'd1000, 16'd10, 1'b0));
        send_item(sample_item(8'h3F, 16'd2000, 16'd0, 1'b1));
        send_item(sample_item(8'hFF, 16'hFFFF, 16'hFFFF, 1'b0));
        // full-scale drop on a packet start marks a turn
        send_item(sample_item(8'h01, 16'h0000, 16'h0001, 1'b1));
        send_item(sample_item(8'h81, 16'd20000, 16'd300, 1'b1));
        // drop exactly at the threshold: no turn
        send_item(sample_item(8'h02, 16'd17000, 16'd301, 1'b1));
        // drop past the threshold but not a packet start: no turn
        send_item(sample_item(8'h03, 16'd13999, 16'd302, 1'b0));
        // drop past the threshold on a packet start: turn
        send_item(sample_item(8'h04, 16'd10998, 16'd303, 1'b1));
        send_item(drain_item(7'd0));
        send_item(drain_item(7'd1));
        // oversized request saturates and returns the rest
        send_item(drain_item(7'd127));
        send_item(drain_item(7'(MAX_DRAIN)));
        wait_quiet();

        // Fill the ring past one full drain with a zero threshold, then
        // drain it to empty.
        write_reg(REG_WRAP_THRESHOLD, 16'd0);
        set_idling(IDLE_BOTH);
        repeat (FILL_COUNT)
        begin
            it = random_sample();
            if (it.raw_quality[5:0] == '0)
                it.raw_quality[0] = 1'b1;
            if (it.sample_distance == '0)
                it.sample_distance = 16'd1;
            send_item(it);
        end
        repeat (FILL_COUNT / MAX_DRAIN + 1) send_item(drain_item(7'(MAX_DRAIN)));

        run_phase(IDLE_NONE, THRESHOLD_RESET, 1'b1, 30);
        run_phase(IDLE_SENDER, 16'hFFFF, 1'b1, 30);
        run_phase(IDLE_RECEIVER, 16'($urandom_range(0, 65535)), 1'b1, 30);
        run_phase(IDLE_BOTH, 16'd0, 1'b1, 30);
        // scanner off with points still held: pushes vanish, drains come back empty
        run_phase(IDLE_BOTH, 16'($urandom_range(0, 65535)), 1'b0, 10);
        run_phase(IDLE_NONE, 16'($urandom_range(0, 65535)), 1'b1, 15);

        wait_quiet();
        repeat (16) @(negedge clk);
        if (fail_count == 0 && pending_points == 0)
            $display("PASS lidar_sample_ring_buffer_unit");
        else
            $display("FAIL lidar_sample_ring_buffer_unit");
        $finish;
    end

endmodule
